// ----- design/tsp_pkg.sv -----
// Package for the thread schedule profiler: state codes, commands, previous-state and window codes.
// No dependencies.
package tsp_pkg;

  localparam int THREADS_DEFAULT   = 256;
  localparam int TIME_BITS_DEFAULT = 48;
  localparam int IDX_W  = 8;
  localparam int CFG_W  = 48;
  localparam int VAL_W  = 64;
  localparam int CNT_W  = 32;
  localparam int TOT_W  = 64;

  localparam logic [2:0] ST_UNKNOWN   = 3'd0;
  localparam logic [2:0] ST_READY     = 3'd1;
  localparam logic [2:0] ST_RUNNING   = 3'd2;
  localparam logic [2:0] ST_STILL     = 3'd3;
  localparam logic [2:0] ST_PREEMPTED = 3'd4;
  localparam logic [2:0] ST_WAITING   = 3'd5;

  localparam logic [1:0] CMD_SCHEDULE = 2'd0;
  localparam logic [1:0] CMD_ENQUEUE  = 2'd1;
  localparam logic [1:0] CMD_REMOVE   = 2'd2;
  localparam logic [1:0] CMD_READ     = 2'd3;

  localparam logic [1:0] PS_WAITING   = 2'd0;
  localparam logic [1:0] PS_SUSPENDED = 2'd1;
  localparam logic [1:0] PS_READY     = 2'd2;

  localparam logic [0:0] CFG_WINDOW_START = 1'b0;
  localparam logic [0:0] CFG_WINDOW_END   = 1'b1;

endpackage

// ----- design/thread_schedule_profiler.sv -----
// Thread schedule profiler top level: per-thread record memory and update sequencer.
// Depends on tsp_pkg.

// Per-thread scheduling statistics. Each beat on the input channel is a schedule,
// enqueue, remove or read command for one thread; each yields exactly one result
// beat (stat_value, ignored, thread_state). Records live in one single-port,
// synchronous-read memory of THREADS entries. The result beat is registered after
// a read and a modify/write of the record for enqueue, remove, read and ignored
// events, and after a second read and write for a schedule that touches two
// threads (the incoming and the outgoing thread share the one port). The next
// input beat is accepted in the cycle after the result beat is taken, so no new
// item enters before the last one is through, and a sink that holds off holds
// the input too. After reset a clearing pass writes every record to its reset
// value, during which no item is accepted; write the window registers only between
// items. Sums and counts saturate; minima and maxima read -1 until the first sample.
module thread_schedule_profiler #(
  parameter int THREADS   = tsp_pkg::THREADS_DEFAULT,
  parameter int TIME_BITS = tsp_pkg::TIME_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [tsp_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    command,
  input  logic [tsp_pkg::CFG_W-1:0]     event_time,
  input  logic [tsp_pkg::IDX_W-1:0]     thread_index,
  input  logic [tsp_pkg::IDX_W-1:0]     previous_thread_index,
  input  logic [1:0]                    previous_state,
  input  logic [3:0]                    stat_select,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [tsp_pkg::VAL_W-1:0] stat_value,
  output logic                          ignored,
  output logic [2:0]                    thread_state
);
  import tsp_pkg::*;

  localparam int AW = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int TW = TIME_BITS;
  localparam int SW = TW + 1;  // signed sample width

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [TOT_W-1:0] total;
    logic [SW-1:0]    smin;
    logic [SW-1:0]    smax;
  } sset_t;

  typedef struct packed {
    logic [2:0]       st;
    logic [TW-1:0]    last;
    sset_t            run;
    sset_t            lat;
    sset_t            rer;
    logic [TOT_W-1:0] idle;
    logic [CNT_W-1:0] pre;
  } rec_t;

  localparam logic [TOT_W-1:0] TOTAL_CAP = {1'b0, {(TOT_W-1){1'b1}}};

  function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] c);
    count_up = (&c) ? c : c + 1'b1;
  endfunction

  function automatic logic [TOT_W-1:0] total_add(input logic [TOT_W-1:0] t,
                                                 input logic [TW-1:0] d);
    logic [TOT_W:0] s;
    s = {1'b0, t} + {{(TOT_W+1-TW){1'b0}}, d};
    total_add = (s > {1'b0, TOTAL_CAP}) ? TOTAL_CAP : s[TOT_W-1:0];
  endfunction

  function automatic sset_t take(input sset_t s, input logic [TW-1:0] d);
    sset_t r;
    logic [SW-1:0] v;
    r = s;
    v = {1'b0, d};
    r.count = count_up(s.count);
    r.total = total_add(s.total, d);
    if (s.smin[SW-1] || ($signed(v) < $signed(s.smin))) r.smin = v;
    if ($signed(v) > $signed(s.smax)) r.smax = v;
    take = r;
  endfunction

  function automatic logic [VAL_W-1:0] sext(input logic [SW-1:0] v);
    sext = {{(VAL_W-SW){v[SW-1]}}, v};
  endfunction

  function automatic rec_t reset_rec();
    rec_t r;
    r = '0;
    r.run.smin = '1; r.run.smax = '1;
    r.lat.smin = '1; r.lat.smax = '1;
    r.rer.smin = '1; r.rer.smax = '1;
    reset_rec = r;
  endfunction

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_RD1, S_UPD1, S_RD2, S_UPD2, S_OUT
  } state_t;

  state_t state;
  rec_t mem [THREADS];
  rec_t rdata;
  logic [AW-1:0] raddr;
  logic          rd_en;
  logic          wr_en;
  logic [AW-1:0] waddr;
  rec_t          wdata;

  logic [AW:0]   clr_cnt;
  logic [TW-1:0] window_start;
  logic [TW-1:0] window_end;

  logic [1:0]        cmd;
  logic [TW-1:0]     now;
  logic [IDX_W-1:0]  ti;
  logic [IDX_W-1:0]  pi;
  logic [1:0]        pstate;
  logic [3:0]        sel;

  logic [AW-1:0]     ti_addr;
  logic [AW-1:0]     pi_addr;
  assign ti_addr = AW'(ti);
  assign pi_addr = AW'(pi);

  // memory, one port, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_start <= '0;
      window_end   <= '1;
    end else if (cfg_write) begin
      if (cfg_index == CFG_WINDOW_START) window_start <= TW'(cfg_data);
      else window_end <= TW'(cfg_data);
    end
  end

  logic ti_ok, pi_ok, in_win;
  assign ti_ok  = {{(32-IDX_W){1'b0}}, ti} < THREADS;
  assign pi_ok  = {{(32-IDX_W){1'b0}}, pi} < THREADS;
  assign in_win = (now >= window_start) && (now < window_end);

  logic [TW-1:0] d;
  assign d = (now >= rdata.last) ? now - rdata.last : '0;

  // incoming-thread update for each command
  rec_t upd1;
  always_comb begin
    upd1 = rdata;
    case (cmd)
      CMD_SCHEDULE: begin
        if (rdata.st == ST_READY) upd1.lat = take(rdata.lat, d);
        else if (rdata.st == ST_PREEMPTED) upd1.rer = take(rdata.rer, d);
        if (rdata.st != ST_RUNNING && rdata.st != ST_STILL) upd1.last = now;
        upd1.st = ST_RUNNING;
      end
      CMD_ENQUEUE: begin
        if (rdata.st == ST_RUNNING || rdata.st == ST_STILL) begin
          upd1.st = ST_STILL;
        end else begin
          if (rdata.st != ST_UNKNOWN) upd1.idle = total_add(rdata.idle, d);
          upd1.last = now;
          upd1.st = ST_READY;
        end
      end
      CMD_REMOVE: begin
        if (rdata.st == ST_RUNNING) upd1.run = take(rdata.run, d);
        else if (rdata.st == ST_READY || rdata.st == ST_PREEMPTED)
          upd1.idle = total_add(rdata.idle, d);
        upd1.last = now;
        upd1.st = ST_WAITING;
      end
      default: upd1 = rdata;
    endcase
  end

  // outgoing-thread update
  rec_t upd2;
  always_comb begin
    upd2 = rdata;
    case (rdata.st)
      ST_STILL: begin
        upd2.run = take(rdata.run, d);
        upd2.pre = count_up(rdata.pre);
        upd2.last = now;
        upd2.st = ST_PREEMPTED;
      end
      ST_RUNNING: begin
        upd2.run = take(rdata.run, d);
        upd2.last = now;
        upd2.st = ST_WAITING;
      end
      ST_UNKNOWN: begin
        if (pstate == PS_WAITING || pstate == PS_SUSPENDED) begin
          upd2.last = now;
          upd2.st = ST_WAITING;
        end else if (pstate == PS_READY) begin
          upd2.last = now;
          upd2.st = ST_PREEMPTED;
        end
      end
      default: upd2 = rdata;
    endcase
  end

  logic [VAL_W-1:0] stat;
  always_comb begin
    case (sel)
      4'd0:  stat = {{(VAL_W-CNT_W){1'b0}}, rdata.run.count};
      4'd1:  stat = rdata.run.total;
      4'd2:  stat = sext(rdata.run.smin);
      4'd3:  stat = sext(rdata.run.smax);
      4'd4:  stat = {{(VAL_W-CNT_W){1'b0}}, rdata.lat.count};
      4'd5:  stat = rdata.lat.total;
      4'd6:  stat = sext(rdata.lat.smin);
      4'd7:  stat = sext(rdata.lat.smax);
      4'd8:  stat = {{(VAL_W-CNT_W){1'b0}}, rdata.rer.count};
      4'd9:  stat = rdata.rer.total;
      4'd10: stat = sext(rdata.rer.smin);
      4'd11: stat = sext(rdata.rer.smax);
      4'd12: stat = rdata.idle;
      4'd13: stat = {{(VAL_W-CNT_W){1'b0}}, rdata.pre};
      4'd14: stat = {{(VAL_W-3){1'b0}}, rdata.st};
      default: stat = {{(VAL_W-TW){1'b0}}, rdata.last};
    endcase
  end

  assign in_ready = (state == S_IDLE);

  // memory control
  always_comb begin
    rd_en = 1'b0;
    raddr = ti_addr;
    wr_en = 1'b0;
    waddr = ti_addr;
    wdata = upd1;
    case (state)
      S_CLEAR: begin
        wr_en = 1'b1;
        waddr = clr_cnt[AW-1:0];
        wdata = reset_rec();
      end
      S_RD1: rd_en = 1'b1;
      S_UPD1: wr_en = ti_ok && (cmd != CMD_READ) && in_win;
      S_RD2: begin
        rd_en = 1'b1;
        raddr = pi_addr;
      end
      S_UPD2: begin
        wr_en = 1'b1;
        waddr = pi_addr;
        wdata = upd2;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (AW+1)'(THREADS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd    <= command;
            now    <= TW'(event_time);
            ti     <= thread_index;
            pi     <= previous_thread_index;
            pstate <= previous_state;
            sel    <= stat_select;
            state  <= S_RD1;
          end
        end
        S_RD1: state <= S_UPD1;
        S_UPD1: begin
          ignored    <= (cmd != CMD_READ) && !in_win;
          stat_value <= (cmd == CMD_READ && ti_ok) ? stat : '0;
          if (!ti_ok) thread_state <= ST_UNKNOWN;
          else if (cmd != CMD_READ && in_win) thread_state <= upd1.st;
          else thread_state <= rdata.st;
          if (cmd == CMD_SCHEDULE && in_win && pi_ok && ti != pi) begin
            state <= S_RD2;
          end else begin
            out_valid <= 1'b1;
            state <= S_OUT;
          end
        end
        S_RD2: state <= S_UPD2;
        S_UPD2: begin
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !in_ready) else $error("accept during clear");
  a_out_only_in_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == S_OUT)) else $error("result outside output state");
  a_no_read_write: assert property (@(posedge clk) disable iff (rst)
    !(rd_en && wr_en)) else $error("port conflict");
  a_read_zero_flag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && cmd == CMD_READ) |-> !ignored) else $error("read flagged");
`endif

endmodule

// ----- verif/thread_schedule_profiler_test.sv -----
// Testbench for the thread schedule profiler: per-thread statistics predictor,
// directed and random event streams, handshake idling. Depends on tsp_pkg.
`timescale 1ns / 100ps

module thread_schedule_profiler_test;
  import tsp_pkg::*;

  localparam int NTHR = 256;
  localparam logic [47:0] TMAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [63:0] TOT_CAP = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int WATCH_LIMIT = 20000;

  typedef struct {
    logic [31:0] cnt;
    logic [63:0] tot;
    logic signed [63:0] mn;
    logic signed [63:0] mx;
  } samples_t;

  typedef struct {
    logic [2:0]  st;
    logic [47:0] last;
    samples_t    run;
    samples_t    lat;
    samples_t    rer;
    logic [63:0] idle;
    logic [31:0] pre;
  } thread_rec_t;

  typedef struct {
    logic signed [63:0] value;
    logic               flag;
    logic [2:0]         state;
  } result_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_write = 0;
  logic cfg_index = 0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] command = CMD_READ;
  logic [CFG_W-1:0] event_time = '0;
  logic [IDX_W-1:0] thread_index = '0;
  logic [IDX_W-1:0] previous_thread_index = '0;
  logic [1:0] previous_state = PS_WAITING;
  logic [3:0] stat_select = '0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [VAL_W-1:0] stat_value;
  logic ignored;
  logic [2:0] thread_state;

  thread_schedule_profiler uut (.*);

  always #4 clk = ~clk;

  // predictor state
  thread_rec_t recs[NTHR];
  logic [47:0] win_lo, win_hi;
  result_t expected_q[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit timed_out = 0;
  bit hold_sink = 0;
  logic [47:0] clock_now;   // running timestamp for well-formed streams

  function automatic logic [31:0] sat_inc(logic [31:0] c);
    return (c == 32'hFFFF_FFFF) ? c : c + 1;
  endfunction

  function automatic logic [63:0] sat_add(logic [63:0] t, logic [63:0] d);
    return (d > TOT_CAP - t) ? TOT_CAP : t + d;
  endfunction

  function automatic void add_sample(ref samples_t s, input logic [63:0] d);
    s.cnt = sat_inc(s.cnt);
    s.tot = sat_add(s.tot, d);
    if (s.mn < 0 || $signed(d) < s.mn) s.mn = d;
    if ($signed(d) > s.mx) s.mx = d;
  endfunction

  function automatic logic [63:0] since(int i, logic [47:0] now);
    return (now >= recs[i].last) ? {16'd0, now - recs[i].last} : 64'd0;
  endfunction

  function automatic void clear_stats();
    foreach (recs[i]) begin
      recs[i].st = ST_UNKNOWN;
      recs[i].last = '0;
      recs[i].run = '{0, 0, -1, -1};
      recs[i].lat = '{0, 0, -1, -1};
      recs[i].rer = '{0, 0, -1, -1};
      recs[i].idle = '0;
      recs[i].pre = '0;
    end
  endfunction

  function automatic logic [63:0] stat_of(int i, logic [3:0] sel);
    case (sel)
      4'd0: return recs[i].run.cnt;
      4'd1: return recs[i].run.tot;
      4'd2: return recs[i].run.mn;
      4'd3: return recs[i].run.mx;
      4'd4: return recs[i].lat.cnt;
      4'd5: return recs[i].lat.tot;
      4'd6: return recs[i].lat.mn;
      4'd7: return recs[i].lat.mx;
      4'd8: return recs[i].rer.cnt;
      4'd9: return recs[i].rer.tot;
      4'd10: return recs[i].rer.mn;
      4'd11: return recs[i].rer.mx;
      4'd12: return recs[i].idle;
      4'd13: return recs[i].pre;
      4'd14: return recs[i].st;
      default: return recs[i].last;
    endcase
  endfunction

  // Computes the result of one event and applies it to the per-thread records.
  function automatic result_t profile_event(logic [1:0] cmd, logic [47:0] now, int ti,
                                            int pi, logic [1:0] ps, logic [3:0] sel);
    result_t r;
    logic [63:0] d;
    r = '{0, 0, 0};
    if (cmd == CMD_READ) begin
      r.value = stat_of(ti, sel);
    end else if (now < win_lo || now >= win_hi) begin
      r.flag = 1;
    end else if (cmd == CMD_SCHEDULE) begin
      d = since(ti, now);
      if (recs[ti].st == ST_READY) add_sample(recs[ti].lat, d);
      else if (recs[ti].st == ST_PREEMPTED) add_sample(recs[ti].rer, d);
      if (recs[ti].st == ST_STILL) recs[ti].st = ST_RUNNING;
      if (recs[ti].st != ST_RUNNING) begin
        recs[ti].last = now;
        recs[ti].st = ST_RUNNING;
      end
      if (pi != ti) begin
        d = since(pi, now);
        case (recs[pi].st)
          ST_STILL: begin
            add_sample(recs[pi].run, d);
            recs[pi].pre = sat_inc(recs[pi].pre);
            recs[pi].last = now;
            recs[pi].st = ST_PREEMPTED;
          end
          ST_RUNNING: begin
            add_sample(recs[pi].run, d);
            recs[pi].last = now;
            recs[pi].st = ST_WAITING;
          end
          ST_UNKNOWN: begin
            if (ps == PS_WAITING || ps == PS_SUSPENDED) begin
              recs[pi].last = now;
              recs[pi].st = ST_WAITING;
            end else if (ps == PS_READY) begin
              recs[pi].last = now;
              recs[pi].st = ST_PREEMPTED;
            end
          end
          default: ;
        endcase
      end
    end else if (cmd == CMD_ENQUEUE) begin
      if (recs[ti].st == ST_RUNNING || recs[ti].st == ST_STILL) begin
        recs[ti].st = ST_STILL;
      end else begin
        if (recs[ti].st != ST_UNKNOWN)
          recs[ti].idle = sat_add(recs[ti].idle, since(ti, now));
        recs[ti].last = now;
        recs[ti].st = ST_READY;
      end
    end else begin
      d = since(ti, now);
      if (recs[ti].st == ST_RUNNING) add_sample(recs[ti].run, d);
      else if (recs[ti].st == ST_READY || recs[ti].st == ST_PREEMPTED)
        recs[ti].idle = sat_add(recs[ti].idle, d);
      recs[ti].last = now;
      recs[ti].st = ST_WAITING;
    end
    r.state = recs[ti].st;
    return r;
  endfunction

  // One beat on the input channel, with a random lead-in gap. Valid stays high
  // into a back-to-back beat; drain() drops it at the end of a stream.
  task automatic send_event(logic [1:0] cmd, logic [47:0] t, int ti, int pi = 0,
                            logic [1:0] ps = PS_WAITING, logic [3:0] sel = 0);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    command <= cmd;
    event_time <= t;
    thread_index <= IDX_W'(ti);
    previous_thread_index <= IDX_W'(pi);
    previous_state <= ps;
    stat_select <= sel;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(profile_event(cmd, t, ti, pi, ps, sel));
    @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [47:0] val);
    @(negedge clk);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 0;
    if (idx == CFG_WINDOW_START) win_lo = val;
    else win_hi = val;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Sink: random stall per beat, a long forced hold when hold_sink is set.
  initial begin
    int stall;
    forever begin
      @(negedge clk);
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (stall != 0 || hold_sink) begin
        out_ready <= 0;
        repeat (stall) @(negedge clk);
        while (hold_sink) @(negedge clk);
      end
      out_ready <= 1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Checker: every output beat against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
      end else begin
        result_t e;
        e = expected_q.pop_front();
        if (e.value !== stat_value || e.flag !== ignored || e.state !== thread_state) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch at %0t: value exp %0d got %0d, ",
                      "ignored exp %0b got %0b, state exp %0d got %0d"},
                     $realtime, e.value, stat_value, e.flag, ignored, e.state,
                     thread_state);
        end
      end
    end
  end

  // Watchdog on cycles with no beat on either channel; covers the clearing pass.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !in_valid && expected_q.size() == 0)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic read_all(int ti);
    for (int s = 0; s < 16; s++) send_event(CMD_READ, 48'($urandom), ti, 0, 0, 4'(s));
  endtask

  task automatic test_directed();
    clock_now = 48'd1000;
    read_all(0);                                      // reset values, minima -1
    send_event(CMD_READ, 0, 255, 255, 3, 15);
    send_event(CMD_ENQUEUE, 100, 3);
    send_event(CMD_SCHEDULE, 150, 3, 7, PS_READY);    // unknown outgoing, ready
    send_event(CMD_SCHEDULE, 160, 4, 8, 2'd3);        // unknown outgoing, other
    send_event(CMD_ENQUEUE, 170, 3);                  // running -> still
    send_event(CMD_SCHEDULE, 200, 5, 3, PS_SUSPENDED);// preemption
    send_event(CMD_SCHEDULE, 120, 3, 5, PS_WAITING);  // time goes backwards
    send_event(CMD_SCHEDULE, 300, 6, 6, PS_WAITING);  // same in and out
    send_event(CMD_REMOVE, 400, 6);
    send_event(CMD_REMOVE, 450, 7);
    send_event(CMD_ENQUEUE, TMAX - 1, 7);
    read_all(3);
  endtask

  task automatic test_window();
    drain();
    write_reg(CFG_WINDOW_START, 48'd500);
    write_reg(CFG_WINDOW_END, 48'd600);
    send_event(CMD_ENQUEUE, 499, 9);
    send_event(CMD_ENQUEUE, 500, 9);
    send_event(CMD_SCHEDULE, 599, 9, 10, PS_READY);
    send_event(CMD_REMOVE, 600, 9);
    send_event(CMD_READ, 700, 9, 0, 0, 14);
    drain();
    write_reg(CFG_WINDOW_START, TMAX);
    write_reg(CFG_WINDOW_END, TMAX);
    send_event(CMD_ENQUEUE, TMAX, 11);
    send_event(CMD_REMOVE, 0, 11);
    drain();
    write_reg(CFG_WINDOW_START, 48'd0);
    write_reg(CFG_WINDOW_END, TMAX);
  endtask

  // Mostly well-formed: a thread pool driven with increasing time, some noise.
  task automatic test_random(int n);
    int ti, pi;
    logic [47:0] t;
    for (int k = 0; k < n; k++) begin
      ti = $urandom_range(0, 15);
      pi = $urandom_range(0, 15);
      clock_now = clock_now + (($urandom_range(0, 20) == 0) ?
                  {$urandom, 16'h0} & 48'h0FFF_FFFF_FFFF : 48'($urandom_range(0, 5000)));
      t = clock_now;
      if ($urandom_range(0, 9) == 0) begin
        ti = $urandom_range(0, 255);
        pi = $urandom_range(0, 255);
        t = {$urandom, $urandom} & TMAX;
      end
      case ($urandom_range(0, 9))
        0, 1, 2: send_event(CMD_SCHEDULE, t, ti, pi, 2'($urandom_range(0, 3)));
        3, 4, 5: send_event(CMD_ENQUEUE, t, ti);
        6: send_event(CMD_REMOVE, t, ti);
        default: send_event(CMD_READ, t, ti, pi, 2'($urandom_range(0, 3)),
                            4'($urandom_range(0, 15)));
      endcase
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_sink = 1;
        repeat (200) @(negedge clk);
        hold_sink = 0;
      end
      test_random(40);
    join
  endtask

  task automatic test_random_windows();
    drain();
    write_reg(CFG_WINDOW_START, clock_now + 48'd2000);
    write_reg(CFG_WINDOW_END, clock_now + 48'd60000);
    test_random(150);
    drain();
    write_reg(CFG_WINDOW_START, 48'd0);
    write_reg(CFG_WINDOW_END, TMAX);
  endtask

  initial begin
    clear_stats();
    win_lo = 0;
    win_hi = TMAX;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    test_directed();
    test_window();
    test_random(500);
    test_backpressure();
    test_random_windows();
    read_all(0);
    test_random(550);
    drain();
    repeat (20) @(negedge clk);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/tsp_pkg.sv
design/thread_schedule_profiler.sv
verif/thread_schedule_profiler_test.sv
